// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks an implication at every rising clock edge, outside of reset.
`define ASSERT_IMPL(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// Checks an invariant at every rising clock edge, including reset.
`define ASSERT_ALWAYS(label, clk, cond) \
    label: assert property (@(posedge clk) (cond)) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/tfsp_pkg.sv =====
`timescale 1ns / 1ps
package tfsp_pkg;
    localparam int NumSeq    = 16;
    localparam int MaxFrames = 16;
    localparam int QDepth    = 8;
    localparam int TimeBits  = 24;
    localparam int SeqW  = $clog2(NumSeq);
    localparam int FrmW  = $clog2(MaxFrames);
    localparam int QW    = $clog2(QDepth);
    localparam int TotW  = $clog2(MaxFrames + 1);
    localparam int SumW  = TimeBits + FrmW + 1;

    typedef enum logic [2:0] {
        FN_TICK  = 3'd0,
        FN_LOAD  = 3'd1,
        FN_COUNT = 3'd2,
        FN_PLAY  = 3'd3,
        FN_QUEUE = 3'd4,
        FN_SKIP  = 3'd5,
        FN_CONT  = 3'd6,
        FN_NOP   = 3'd7
    } t_func;
endpackage

// ===== hw/rtl/timed_frame_sequence_player.sv =====
`timescale 1ns / 1ps
// A non-tick item is executed and its result registered. A tick steps the head sequence
// frame by frame, pops a sequence per completion while a continue is left, and, when no
// continue is left, sums the frame durations and folds whole loops away.
// Items are taken one at a time; a stalled result holds back the next result, not the input.
// Reset (synchronous, active low) empties the queue, clears the continue count and marks
// every sequence as restarted through per-sequence valid bits.
`include "assert_macros.svh"
module timed_frame_sequence_player (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // func[2:0], seq_index[6:3], frame_index[10:7], amount[34:11], zeros
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // active[0], current_sequence[4:1], current_frame[8:5], queued_count[12:9],
    // continues_left[36:13], overflow[37], zeros
    output logic [39:0] m_axis_tdata
);
    localparam int SeqW = tfsp_pkg::SeqW;
    localparam int FrmW = tfsp_pkg::FrmW;
    localparam int QW   = tfsp_pkg::QW;
    localparam int TB   = tfsp_pkg::TimeBits;
    localparam int TotW = tfsp_pkg::TotW;
    localparam int SumW = tfsp_pkg::SumW;
    localparam int ModW = SumW + 1;
    localparam int CntW = $clog2(SumW);

    typedef enum logic [3:0] {
        ST_IDLE, ST_EXEC, ST_LD_RD, ST_LD, ST_STEP_RD, ST_STEP, ST_WB, ST_NEXT,
        ST_SUM_RD, ST_SUM, ST_MOD, ST_HEAD, ST_POSRD, ST_OUT
    } t_state;

    // Memories.
    logic [TB-1:0]   m_dur [tfsp_pkg::NumSeq*tfsp_pkg::MaxFrames];
    logic [TotW-1:0] m_tot [tfsp_pkg::NumSeq];
    logic [FrmW-1:0] m_pos [tfsp_pkg::NumSeq];
    logic [TB-1:0]   m_el  [tfsp_pkg::NumSeq];
    logic [SeqW-1:0] m_fifo [tfsp_pkg::QDepth];
    logic [tfsp_pkg::NumSeq-1:0] r_valid;

    t_state             r_state;
    tfsp_pkg::t_func    r_func;
    logic [SeqW-1:0]    r_sidx;
    logic [FrmW-1:0]    r_fidx;
    logic [23:0]        r_amt;
    logic [QW-1:0]      r_head;
    logic [QW:0]        r_fill;
    logic [23:0]        r_cont;
    logic               r_ovf;
    logic [SeqW-1:0]    r_cur;       // sequence being advanced
    logic [SumW-1:0]    r_el;        // elapsed plus tick, may exceed TB during a step
    logic [FrmW-1:0]    r_pos;
    logic [TotW-1:0]    r_tot;
    logic [TotW-1:0]    r_fcnt;
    logic [SumW-1:0]    r_sum;
    logic [ModW-1:0]    r_rem;
    logic [SumW-1:0]    r_dvd;
    logic [CntW-1:0]    r_mcnt;
    logic               r_done;
    logic               r_pop;
    logic [TB-1:0]      r_el_rd;
    logic [FrmW-1:0]    r_pos_rd;
    logic [TotW-1:0]    r_tot_rd;
    logic [TB-1:0]      r_dur_rd;
    logic [SeqW-1:0]    r_head_rd;
    logic               r_oval;
    logic [39:0]        r_odata;

    logic [FrmW-1:0]  dur_f;
    logic [SeqW-1:0]  pos_addr;
    logic [TB-1:0]    dur_eff;
    logic [TotW-1:0]  tot_eff;
    logic [TotW-1:0]  pos_inc;
    logic [TotW-1:0]  fcnt_inc;
    logic [ModW-1:0]  mod_shl;
    logic [ModW-1:0]  mod_try;
    logic [ModW-1:0]  n_rem;
    logic             out_load;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_oval;
    assign m_axis_tdata  = r_odata;

    assign dur_eff  = (r_dur_rd == '0) ? TB'(1) : r_dur_rd;
    assign tot_eff  = (r_tot == '0) ? TotW'(1) : r_tot;
    assign pos_inc  = TotW'(r_pos) + TotW'(1);
    assign fcnt_inc = r_fcnt + TotW'(1);
    assign mod_shl  = {r_rem[SumW-1:0], r_dvd[SumW-1]};
    assign mod_try  = mod_shl - {1'b0, r_sum};
    assign n_rem    = mod_try[ModW-1] ? mod_shl : mod_try;
    // A new result may be formed once the previous one has left.
    assign out_load = (r_state == ST_OUT) && (!r_oval || m_axis_tready);

    // Duration memory address: stepping frame, or summing frame; position address: head or current.
    always_comb begin
        dur_f    = (r_state == ST_SUM_RD) ? r_fcnt[FrmW-1:0] : r_pos;
        pos_addr = (r_state == ST_POSRD) ? r_head_rd : r_cur;
    end

    always_ff @(posedge i_clk) begin
        r_dur_rd  <= m_dur[{r_cur, dur_f}];
        r_el_rd   <= m_el[r_cur];
        r_pos_rd  <= m_pos[pos_addr];
        r_tot_rd  <= m_tot[r_cur];
        r_head_rd <= m_fifo[r_head];
        if (r_state == ST_EXEC) begin
            if (r_func == tfsp_pkg::FN_LOAD) begin
                m_dur[{r_sidx, r_fidx}] <= r_amt[TB-1:0];
            end
            if (r_func == tfsp_pkg::FN_COUNT) begin
                m_tot[r_sidx] <= (r_amt > 24'(tfsp_pkg::MaxFrames)) ?
                    TotW'(tfsp_pkg::MaxFrames) : r_amt[TotW-1:0];
            end
            if (r_func == tfsp_pkg::FN_PLAY) begin
                m_fifo[QW'(0)] <= r_sidx;
            end
            if (r_func == tfsp_pkg::FN_QUEUE && r_fill != (QW+1)'(tfsp_pkg::QDepth)) begin
                m_fifo[QW'({1'b0, r_head} + r_fill)] <= r_sidx;
            end
        end
        if (r_state == ST_WB) begin
            m_pos[r_cur] <= r_pos;
            m_el[r_cur]  <= r_done ? TB'(0) : r_el[TB-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= '0;
            r_head  <= '0;
            r_fill  <= '0;
            r_cont  <= '0;
            r_oval  <= 1'b0;
        end else begin
            if (out_load) r_oval <= 1'b1;
            else if (m_axis_tready) r_oval <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_func  <= tfsp_pkg::t_func'(s_axis_tdata[2:0]);
                        r_sidx  <= s_axis_tdata[6:3];
                        r_fidx  <= s_axis_tdata[10:7];
                        r_amt   <= s_axis_tdata[34:11];
                        r_ovf   <= 1'b0;
                        r_state <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    r_state <= ST_HEAD;
                    unique case (r_func)
                        tfsp_pkg::FN_TICK: begin
                            if (r_fill != '0 && r_amt[TB-1:0] != '0) begin
                                r_cur   <= r_head_rd;
                                r_el    <= SumW'(r_amt[TB-1:0]);
                                r_state <= ST_LD_RD;
                            end
                        end
                        tfsp_pkg::FN_COUNT: begin
                            r_valid[r_sidx] <= 1'b0;
                        end
                        tfsp_pkg::FN_PLAY: begin
                            r_cont <= '0;
                            r_head <= '0;
                            r_fill <= (QW+1)'(1);
                        end
                        tfsp_pkg::FN_QUEUE: begin
                            if (r_fill == (QW+1)'(tfsp_pkg::QDepth)) r_ovf <= 1'b1;
                            else r_fill <= r_fill + 1'b1;
                        end
                        tfsp_pkg::FN_SKIP: begin
                            if (r_cont != '0) r_cont <= r_cont - 1'b1;
                            if (r_fill != '0) begin
                                r_head <= r_head + 1'b1;
                                r_fill <= r_fill - 1'b1;
                            end
                        end
                        tfsp_pkg::FN_CONT: r_cont <= r_amt;
                        default: ;
                    endcase
                end
                ST_LD_RD: r_state <= ST_LD;
                ST_LD: begin
                    // A sequence without a valid bit starts from frame zero, time zero.
                    r_tot   <= r_tot_rd;
                    r_pos   <= r_valid[r_cur] ? r_pos_rd : FrmW'(0);
                    r_el    <= r_el + SumW'(r_valid[r_cur] ? r_el_rd : TB'(0));
                    r_state <= ST_STEP_RD;
                end
                ST_STEP_RD: r_state <= ST_STEP;
                ST_STEP: begin
                    if (r_el >= SumW'(dur_eff)) begin
                        r_el <= r_el - SumW'(dur_eff);
                        if (pos_inc >= tot_eff) begin
                            // Completion: the leftover stays in r_el.
                            r_pos   <= '0;
                            r_done  <= 1'b1;
                            r_state <= ST_WB;
                            if (r_cont != '0) begin
                                r_cont <= r_cont - 1'b1;
                                r_head <= r_head + 1'b1;
                                r_fill <= r_fill - 1'b1;
                                r_pop  <= 1'b1;
                            end else begin
                                r_pop  <= 1'b0;
                            end
                        end else begin
                            r_pos   <= r_pos + 1'b1;
                            r_state <= ST_STEP_RD;
                        end
                    end else begin
                        r_done  <= 1'b0;
                        r_state <= ST_WB;
                    end
                end
                ST_WB: begin
                    r_valid[r_cur] <= 1'b1;
                    if (!r_done) begin
                        r_state <= ST_HEAD;
                    end else if (r_pop) begin
                        r_state <= (r_fill == '0) ? ST_HEAD : ST_NEXT;
                    end else begin
                        r_fcnt  <= '0;
                        r_sum   <= '0;
                        r_state <= ST_SUM_RD;
                    end
                end
                ST_NEXT: begin
                    // The new head carries on with the leftover time.
                    r_cur   <= r_head_rd;
                    r_state <= ST_LD_RD;
                end
                ST_SUM_RD: r_state <= ST_SUM;
                ST_SUM: begin
                    r_sum  <= r_sum + SumW'(dur_eff);
                    r_fcnt <= fcnt_inc;
                    if (fcnt_inc >= tot_eff) begin
                        r_state <= ST_MOD;
                        r_rem   <= '0;
                        r_dvd   <= r_el;
                        r_mcnt  <= '0;
                    end else begin
                        r_state <= ST_SUM_RD;
                    end
                end
                ST_MOD: begin
                    // Restoring division, one quotient bit per cycle; only the remainder is kept.
                    r_dvd  <= {r_dvd[SumW-2:0], 1'b0};
                    r_rem  <= n_rem;
                    r_mcnt <= r_mcnt + 1'b1;
                    if (r_mcnt == CntW'(SumW - 1)) begin
                        r_el    <= n_rem[SumW-1:0];
                        r_state <= ST_LD_RD;
                    end
                end
                ST_HEAD: r_state <= ST_POSRD;
                ST_POSRD: r_state <= ST_OUT;
                ST_OUT: begin
                    if (out_load) begin
                        r_odata <= {2'b0, r_ovf, r_cont, r_fill,
                                    (r_fill != '0 && r_valid[r_head_rd]) ? r_pos_rd : FrmW'(0),
                                    (r_fill != '0) ? r_head_rd : SeqW'(0), r_fill != '0};
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    `ASSERT_IMPL(a_out_hold, i_clk, i_rst_n, (r_oval && !m_axis_tready) |=> r_oval)
    `ASSERT_IMPL(a_out_stable, i_clk, i_rst_n,
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    `ASSERT_IMPL(a_fill_range, i_clk, i_rst_n,
        r_fill <= (QW+1)'(tfsp_pkg::QDepth))
    `ASSERT_IMPL(a_no_accept_busy, i_clk, i_rst_n,
        (r_state != ST_IDLE) |-> !s_axis_tready)
endmodule
